@@ rtl/med_pkg.sv @@
// ----------------------------------------------------------------------------
// med_pkg: shared types and constants for the motion event detector
// Register indexes, event codes, field widths and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package med_pkg;

   // default widths of the sample and time fields
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TIME_BITS_DEF   = 32;

   // fixed field widths
   localparam int THRESH_BITS = 16;
   localparam int WINDOW_BITS = 32;
   localparam int DEVICE_BITS = 16;
   localparam int EVT_TIME_BITS = 32;
   localparam int MAG_BITS    = 16;
   localparam int KIND_BITS   = 2;

   // configuration port
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_WINDOW    = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_TAG       = 2'd2;

   // event kinds
   localparam logic [KIND_BITS-1:0] KIND_START    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_CONTINUE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_STOP     = 2'd2;

   // axis select for the shared squarer
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // number of squaring cycles (three products, one trailing add)
   localparam int SQ_CYCLES = 4;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture a valid sample, clear accumulators
      logic       sq_en;      // square the selected axis
      logic [1:0] sq_sel;     // axis for the squarer
      logic       acc_en;     // add last product into the sum
      logic       root_step;  // one digit of the square root
      logic       commit;     // write the result and update motion state
   } med_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic evt;       // the finished sample produces an event
      logic out_busy;  // result register full and not being taken
   } med_sts_type;

endpackage

@@ rtl/med_ctrl.sv @@
// ----------------------------------------------------------------------------
// med_ctrl: sequencer for the motion event detector
// Accepts one sample, steps the squarer and the square root loop, then
// commits any event into the result register once it is free.
// ----------------------------------------------------------------------------
module med_ctrl #(
   parameter int SAMPLE_BITS = med_pkg::SAMPLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_sample_valid,
   output logic                 req_stall,
   output med_pkg::med_cmd_type cmd,
   input  med_pkg::med_sts_type sts
);

   localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);
   localparam logic [CNT_BITS-1:0] SQ_LAST   = CNT_BITS'(med_pkg::SQ_CYCLES - 1);
   localparam logic [CNT_BITS-1:0] SQ_MULS   = CNT_BITS'(med_pkg::SQ_CYCLES - 1);
   localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(SAMPLE_BITS - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SQ   = 2'd1;
   localparam logic [1:0] S_ROOT = 2'd2;
   localparam logic [1:0] S_DEC  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                take;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall && req_sample_valid;

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (take) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (cnt_ff == SQ_LAST) begin
               state_in = S_ROOT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               state_in = S_DEC;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DEC: begin
            if (!sts.evt || !sts.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // commands
   always_comb begin
      cmd           = '0;
      cmd.load      = take;
      cmd.sq_en     = (state_ff == S_SQ) && (cnt_ff < SQ_MULS);
      cmd.sq_sel    = cnt_ff[1:0];
      cmd.acc_en    = (state_ff == S_SQ) && (cnt_ff != '0);
      cmd.root_step = (state_ff == S_ROOT);
      cmd.commit    = (state_ff == S_DEC) && sts.evt && !sts.out_busy;
   end

endmodule

@@ rtl/med_dp.sv @@
// ----------------------------------------------------------------------------
// med_dp: datapath of the motion event detector
// Configuration registers, absolute values, shared squarer and sum,
// digit-by-digit square root, motion decision and result register.
// ----------------------------------------------------------------------------
module med_dp #(
   parameter int SAMPLE_BITS = med_pkg::SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = med_pkg::TIME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [med_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [med_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   // sample
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_z,
   input  logic [TIME_BITS-1:0]                  req_now_ms,
   // result
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [med_pkg::DEVICE_BITS-1:0]       rsp_event_device,
   output logic [med_pkg::EVT_TIME_BITS-1:0]     rsp_event_time,
   output logic [med_pkg::MAG_BITS-1:0]          rsp_event_magnitude,
   output logic [med_pkg::KIND_BITS-1:0]         rsp_event_kind,
   // control
   input  med_pkg::med_cmd_type                  cmd,
   output med_pkg::med_sts_type                  sts
);

   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int REM_BITS = SAMPLE_BITS + 2;
   localparam int CMP_BITS = (SAMPLE_BITS > med_pkg::THRESH_BITS) ?
                             SAMPLE_BITS : med_pkg::THRESH_BITS;
   localparam int EL_BITS  = (TIME_BITS > med_pkg::WINDOW_BITS) ?
                             TIME_BITS : med_pkg::WINDOW_BITS;
   localparam logic [CMP_BITS-1:0] MAG_MAX = CMP_BITS'({med_pkg::MAG_BITS{1'b1}});

   // configuration registers
   logic [med_pkg::THRESH_BITS-1:0] thresh_ff;
   logic [med_pkg::WINDOW_BITS-1:0] window_ff;
   logic [med_pkg::DEVICE_BITS-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         window_ff <= '0;
         tag_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            med_pkg::REG_THRESHOLD: thresh_ff <= csr_wdata[med_pkg::THRESH_BITS-1:0];
            med_pkg::REG_WINDOW:    window_ff <= csr_wdata[med_pkg::WINDOW_BITS-1:0];
            med_pkg::REG_TAG:       tag_ff    <= csr_wdata[med_pkg::DEVICE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // absolute values of the axes; the most negative count maps to 2^(N-1)
   logic [SAMPLE_BITS-1:0] ux, uy, uz;
   logic [SAMPLE_BITS-1:0] abs_x_in, abs_y_in, abs_z_in;
   logic [SAMPLE_BITS-1:0] abs_x_ff, abs_y_ff, abs_z_ff;
   logic [TIME_BITS-1:0]   now_ff;

   assign ux = req_accel_x;
   assign uy = req_accel_y;
   assign uz = req_accel_z;
   assign abs_x_in = ux[SAMPLE_BITS-1] ? (~ux + 1'b1) : ux;
   assign abs_y_in = uy[SAMPLE_BITS-1] ? (~uy + 1'b1) : uy;
   assign abs_z_in = uz[SAMPLE_BITS-1] ? (~uz + 1'b1) : uz;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
         abs_z_ff <= abs_z_in;
         now_ff   <= req_now_ms;
      end
   end

   // shared squarer, product registered before the add
   logic [SAMPLE_BITS-1:0] sq_op;
   logic [SQ_BITS-1:0]     sq_wide;
   logic [SQ_BITS-1:0]     prod_ff, prod_in;

   always_comb begin
      case (cmd.sq_sel)
         med_pkg::AXIS_X: sq_op = abs_x_ff;
         med_pkg::AXIS_Y: sq_op = abs_y_ff;
         default:         sq_op = abs_z_ff;
      endcase
   end

   assign sq_wide = SQ_BITS'(sq_op);
   assign prod_in = sq_wide * sq_wide;

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         prod_ff <= prod_in;
      end
   end

   // sum of squares; the same register then feeds the root two bits a step
   logic [SQ_BITS-1:0]     acc_ff;
   logic [REM_BITS-1:0]    rem_ff, rem_sh, trial;
   logic [SAMPLE_BITS-1:0] root_ff;
   logic                   fits;

   assign rem_sh = {rem_ff[SAMPLE_BITS-1:0], acc_ff[SQ_BITS-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + prod_ff;
      end else if (cmd.root_step) begin
         acc_ff  <= {acc_ff[SQ_BITS-3:0], 2'b00};
         rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[SAMPLE_BITS-2:0], fits};
      end
   end

   // motion decision
   logic                    moving_ff;
   logic [TIME_BITS-1:0]    last_ff;
   logic [TIME_BITS-1:0]    elapsed;
   logic                    over_thresh, quiet_long;
   logic [med_pkg::KIND_BITS-1:0] kind;
   logic [med_pkg::MAG_BITS-1:0]  mag_sat;

   assign over_thresh = CMP_BITS'(root_ff) > CMP_BITS'(thresh_ff);
   assign elapsed     = now_ff - last_ff;
   assign quiet_long  = EL_BITS'(elapsed) > EL_BITS'(window_ff);
   assign mag_sat     = (CMP_BITS'(root_ff) > MAG_MAX) ?
                        {med_pkg::MAG_BITS{1'b1}} : med_pkg::MAG_BITS'(root_ff);

   always_comb begin
      if (over_thresh) begin
         kind = moving_ff ? med_pkg::KIND_CONTINUE : med_pkg::KIND_START;
      end else begin
         kind = med_pkg::KIND_STOP;
      end
   end

   assign sts.evt      = over_thresh || (moving_ff && quiet_long);
   assign sts.out_busy = rsp_valid && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff <= 1'b0;
         last_ff   <= '0;
      end else if (cmd.commit) begin
         moving_ff <= over_thresh;
         if (over_thresh) begin
            last_ff <= now_ff;
         end
      end
   end

   // result register
   logic                              rsp_valid_ff;
   logic [med_pkg::DEVICE_BITS-1:0]   dev_ff;
   logic [med_pkg::EVT_TIME_BITS-1:0] time_ff;
   logic [med_pkg::MAG_BITS-1:0]      mag_ff;
   logic [med_pkg::KIND_BITS-1:0]     kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         dev_ff  <= tag_ff;
         time_ff <= med_pkg::EVT_TIME_BITS'(now_ff);
         mag_ff  <= mag_sat;
         kind_ff <= kind;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_device    = dev_ff;
   assign rsp_event_time      = time_ff;
   assign rsp_event_magnitude = mag_ff;
   assign rsp_event_kind      = kind_ff;

endmodule

@@ rtl/motion_event_detector.sv @@
// ----------------------------------------------------------------------------
// motion_event_detector: accelerometer magnitude threshold motion detector
// Magnitude is the floor square root of the summed squared axes; a sample
// above threshold reports start or continue, a long quiet spell reports stop.
// ----------------------------------------------------------------------------
//
//   channel | direction | transfer when        | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid & !stall   | sample_valid, accel_x/y/z, now
//   rsp     | out       | rsp_valid & !stall   | device, time, magnitude, kind
//   csr     | in        | csr_we               | csr_addr, csr_wdata
//
// A valid sample is captured, squared and summed in the shared squarer,
// run through the square root loop one root bit per step, then decided.
// An invalid sample is taken without leaving the idle state.
// Reset is synchronous and clears the motion state, configuration registers, sequencer and rsp_valid.
// A stalled result holds in the output register while the next sample is
// taken; only a new event waits for it to leave.
//
module motion_event_detector #(
   parameter int SAMPLE_BITS = med_pkg::SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = med_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [med_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [med_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_sample_valid,
   input  logic signed [SAMPLE_BITS-1:0]     req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]     req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]     req_accel_z,
   input  logic [TIME_BITS-1:0]              req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [med_pkg::DEVICE_BITS-1:0]   rsp_event_device,
   output logic [med_pkg::EVT_TIME_BITS-1:0] rsp_event_time,
   output logic [med_pkg::MAG_BITS-1:0]      rsp_event_magnitude,
   output logic [med_pkg::KIND_BITS-1:0]     rsp_event_kind
);

   med_pkg::med_cmd_type cmd;
   med_pkg::med_sts_type sts;

   med_ctrl #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_sample_valid(req_sample_valid),
      .req_stall       (req_stall),
      .cmd             (cmd),
      .sts             (sts)
   );

   med_dp #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_device   (rsp_event_device),
      .rsp_event_time     (rsp_event_time),
      .rsp_event_magnitude(rsp_event_magnitude),
      .rsp_event_kind     (rsp_event_kind),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

@@ rtl/med_checker.sv @@
// ----------------------------------------------------------------------------
// med_checker: port-level checks for the motion event detector
// Watches the top level's ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module med_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_sample_valid,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [med_pkg::EVT_TIME_BITS-1:0] rsp_event_time,
   input logic [med_pkg::MAG_BITS-1:0]      rsp_event_magnitude,
   input logic [med_pkg::KIND_BITS-1:0]     rsp_event_kind
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_event_time) && $stable(rsp_event_magnitude))
      else $error("stalled result changed");

   // only start, continue or stop are ever reported
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == med_pkg::KIND_START ||
                     rsp_event_kind == med_pkg::KIND_CONTINUE ||
                     rsp_event_kind == med_pkg::KIND_STOP))
      else $error("undefined event kind");

   // a valid sample that is taken makes the input side busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_sample_valid |=> req_stall)
      else $error("input not stalled after a valid sample");

   // an invalid sample leaves the input side free
   a_skip_invalid: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_sample_valid |=> !req_stall)
      else $error("invalid sample occupied the block");

   // reset empties the result register and frees the input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

endmodule

bind motion_event_detector med_checker u_med_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_sample_valid   (req_sample_valid),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_event_time     (rsp_event_time),
   .rsp_event_magnitude(rsp_event_magnitude),
   .rsp_event_kind     (rsp_event_kind)
);
